// ===== design/lse_pkg.sv =====
// Shared types and constants of the LSB payload extractor.
package lse_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HDR_WORD_W = 64;
  localparam int unsigned HDR_LEN_W  = 4;
  localparam int unsigned LEN_W      = 27;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned BITPOS_W   = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [HDR_LEN_W-1:0] HDR_LEN_RESET = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_WORD   = 1'd0,
    CFG_HEADER_LENGTH = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_DONE    = 2'd3
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DATA        = 2'd0,
    ST_BAD_HEADER  = 2'd1,
    ST_ZERO_LENGTH = 2'd2
  } status_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    status_e           status;
    logic              last;
  } result_t;

endpackage

// ===== design/lse_if.sv =====
// Stream interfaces for the pixel input and the result output.
interface lse_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [lse_pkg::BYTE_W-1:0]    red_sample;
  logic                          first_pixel;

  modport source (output valid, output red_sample, output first_pixel, input ready);
  modport sink   (input valid, input red_sample, input first_pixel, output ready);
endinterface

interface lse_result_if;
  logic                          valid;
  logic                          ready;
  logic [lse_pkg::BYTE_W-1:0]    data_byte;
  logic [lse_pkg::STATUS_W-1:0]  status;
  logic                          last;

  modport source (output valid, output data_byte, output status, output last, input ready);
  modport sink   (input valid, input data_byte, input status, input last, output ready);
endinterface

// ===== design/lse_parser.sv =====
// Parse state and per-pixel step logic: header match, length digits, payload.
module lse_parser #(
  parameter int unsigned HEADER_MAX_BYTES  = 8,
  parameter int unsigned LENGTH_MAX_DIGITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic                             sample_bit_i,
  input  logic                             first_pixel_i,
  input  logic [lse_pkg::HDR_WORD_W-1:0]   header_word_i,
  input  logic [lse_pkg::HDR_LEN_W-1:0]    header_length_i,
  output logic                             res_valid_o,
  output lse_pkg::result_t                 res_o
);
  import lse_pkg::*;

  logic [BYTE_W-1:0]   gather_q,   gather_d;
  logic [BITPOS_W-1:0] bitpos_q,   bitpos_d;
  phase_e              phase_q,    phase_d;
  logic [POS_W-1:0]    bytepos_q,  bytepos_d;
  logic                hdr_ok_q,   hdr_ok_d;
  logic [LEN_W-1:0]    length_q,   length_d;
  logic [LEN_W-1:0]    left_q,     left_d;

  // Values seen by this pixel: a first pixel starts from the restart state.
  logic [BYTE_W-1:0]   c_gather;
  logic [BITPOS_W-1:0] c_bitpos;
  phase_e              c_phase;
  logic [POS_W-1:0]    c_bytepos;
  logic                c_hdr_ok;
  logic [LEN_W-1:0]    c_length;
  logic [LEN_W-1:0]    c_left;

  logic [HDR_LEN_W-1:0]           eff_len;
  logic [HDR_WORD_W/BYTE_W-1:0][BYTE_W-1:0] hdr_bytes;
  logic [BITPOS_W-1:0]            hdr_idx;
  logic [BYTE_W-1:0]              new_byte;
  logic                           in_range;
  logic                           hdr_ok_n;
  logic                           hdr_end;
  logic                           is_digit;
  logic [LEN_W-1:0]               length_n;
  logic [POS_W-1:0]               digits_n;
  logic [LEN_W-1:0]               left_cur;
  logic                           go_payload;

  always_comb begin
    if (first_pixel_i) begin
      c_gather  = '0;
      c_bitpos  = '0;
      c_phase   = PH_HEADER;
      c_bytepos = '0;
      c_hdr_ok  = 1'b1;
      c_length  = '0;
      c_left    = '0;
    end else begin
      c_gather  = gather_q;
      c_bitpos  = bitpos_q;
      c_phase   = phase_q;
      c_bytepos = bytepos_q;
      c_hdr_ok  = hdr_ok_q;
      c_length  = length_q;
      c_left    = left_q;
    end
  end

  // Header length clamped to the supported range.
  always_comb begin
    if (header_length_i == '0) begin
      eff_len = HDR_LEN_W'(1);
    end else if (header_length_i > HDR_LEN_W'(HEADER_MAX_BYTES)) begin
      eff_len = HDR_LEN_W'(HEADER_MAX_BYTES);
    end else begin
      eff_len = header_length_i;
    end
  end

  assign hdr_bytes = header_word_i;
  assign new_byte  = {c_gather[BYTE_W-2:0], sample_bit_i};
  assign in_range  = c_bytepos < eff_len;
  assign hdr_idx   = BITPOS_W'(eff_len - HDR_LEN_W'(1) - c_bytepos);
  assign hdr_ok_n  = c_hdr_ok & in_range & (new_byte == hdr_bytes[hdr_idx]);
  assign hdr_end   = ({1'b0, c_bytepos} + 5'd1) >= {1'b0, eff_len};
  assign is_digit  = (new_byte >= 8'h30) && (new_byte <= 8'h39)
                     && (c_bytepos < POS_W'(LENGTH_MAX_DIGITS));
  // Decimal accumulate: ten times the length plus the digit, kept to 27 bits.
  assign length_n  = (c_length << 3) + (c_length << 1) + LEN_W'(new_byte[3:0]);
  assign digits_n  = c_bytepos + POS_W'(1);

  always_comb begin
    gather_d    = c_gather;
    bitpos_d    = c_bitpos;
    phase_d     = c_phase;
    bytepos_d   = c_bytepos;
    hdr_ok_d    = c_hdr_ok;
    length_d    = c_length;
    left_d      = c_left;
    res_valid_o = 1'b0;
    res_o       = '{data_byte: '0, status: ST_DATA, last: 1'b0};
    left_cur    = c_left;
    go_payload  = 1'b0;

    if (c_phase != PH_DONE) begin
      if (c_bitpos != '1) begin
        gather_d = new_byte;
        bitpos_d = c_bitpos + BITPOS_W'(1);
      end else begin
        gather_d = '0;
        bitpos_d = '0;
        case (c_phase)
          PH_HEADER: begin
            hdr_ok_d = hdr_ok_n;
            if (hdr_end) begin
              if (hdr_ok_n) begin
                phase_d   = PH_LENGTH;
                bytepos_d = '0;
                length_d  = '0;
              end else begin
                phase_d     = PH_DONE;
                res_valid_o = 1'b1;
                res_o       = '{data_byte: '0, status: ST_BAD_HEADER, last: 1'b1};
              end
            end else begin
              bytepos_d = c_bytepos + POS_W'(1);
            end
          end
          PH_LENGTH: begin
            if (is_digit) begin
              length_d  = length_n;
              bytepos_d = digits_n;
              if (digits_n >= POS_W'(LENGTH_MAX_DIGITS)) begin
                if (length_n == '0) begin
                  phase_d     = PH_DONE;
                  res_valid_o = 1'b1;
                  res_o       = '{data_byte: '0, status: ST_ZERO_LENGTH, last: 1'b1};
                end else begin
                  phase_d = PH_PAYLOAD;
                  left_d  = length_n;
                end
              end
            end else if (c_length == '0) begin
              phase_d     = PH_DONE;
              res_valid_o = 1'b1;
              res_o       = '{data_byte: '0, status: ST_ZERO_LENGTH, last: 1'b1};
            end else begin
              // The byte that ends the digit run is the first payload byte.
              left_cur   = c_length;
              go_payload = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            go_payload = 1'b1;
          end
          default: begin
          end
        endcase

        if (go_payload) begin
          if (left_cur == '0) begin
            phase_d = PH_DONE;
            left_d  = '0;
          end else begin
            phase_d     = (left_cur == LEN_W'(1)) ? PH_DONE : PH_PAYLOAD;
            left_d      = left_cur - LEN_W'(1);
            res_valid_o = 1'b1;
            res_o       = '{data_byte: new_byte, status: ST_DATA,
                            last: (left_cur == LEN_W'(1))};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gather_q  <= '0;
      bitpos_q  <= '0;
      phase_q   <= PH_HEADER;
      bytepos_q <= '0;
      hdr_ok_q  <= 1'b1;
      length_q  <= '0;
      left_q    <= '0;
    end else if (step_i) begin
      gather_q  <= gather_d;
      bitpos_q  <= bitpos_d;
      phase_q   <= phase_d;
      bytepos_q <= bytepos_d;
      hdr_ok_q  <= hdr_ok_d;
      length_q  <= length_d;
      left_q    <= left_d;
    end
  end

`ifndef SYNTHESIS
  // Once finished, only a first pixel can leave the done phase.
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE && !(step_i && first_pixel_i)) |=> (phase_q == PH_DONE))
    else $error("parser left the done phase without a first pixel");

  // A result can only come from the pixel that completes a byte.
  a_result_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o) |-> (c_bitpos == '1))
    else $error("result produced in the middle of a byte");
`endif

endmodule

// ===== design/lsb_stego_payload_extractor.sv =====
// Top level of the LSB payload extractor: input stage, parser, output register.
// A result reaches res_o through the input register, where its pixel waits, and the
// output register, which the parser step for that pixel writes.
// Throughput: one pixel per cycle unless the result port stalls, one parser step per clock.
// A stalled result port holds the output register and, one pixel later, the input.
// Reset (rst_ni, asynchronous, active low) clears both stages, restarts parsing
// and returns header_word to zero and header_length to four.
module lsb_stego_payload_extractor #(
  parameter int unsigned HEADER_MAX_BYTES  = 8,
  parameter int unsigned LENGTH_MAX_DIGITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lse_pixel_if.sink                        pix_i,
  lse_result_if.source                     res_o,
  input  logic                             cfg_we_i,
  input  logic [lse_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lse_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import lse_pkg::*;

  // Configuration registers.
  logic [HDR_WORD_W-1:0] header_word_q;
  logic [HDR_LEN_W-1:0]  header_length_q;

  // Input stage: only bit 0 of the red value and the first-pixel flag matter.
  logic    s1_valid_q, s1_valid_d;
  logic    s1_bit_q;
  logic    s1_first_q;

  // Output register.
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  logic    out_free;
  logic    s1_adv;
  logic    pix_accept;
  logic    res_valid;
  result_t res;

  // The output register is free when empty or being read this cycle; the
  // input stage moves on whenever it is.
  assign out_free   = !out_valid_q || res_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign pix_i.ready = !s1_valid_q || out_free;
  assign pix_accept = pix_i.valid && pix_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pix_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = s1_adv && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_accept) begin
      s1_bit_q   <= pix_i.red_sample[0];
      s1_first_q <= pix_i.first_pixel;
    end
    if (s1_adv && res_valid) begin
      out_q <= res;
    end
  end

  // Configuration writes take effect on the next clock.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_word_q   <= '0;
      header_length_q <= HDR_LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HEADER_WORD:   header_word_q   <= cfg_data_i;
        CFG_HEADER_LENGTH: header_length_q <= cfg_data_i[HDR_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lse_parser #(
    .HEADER_MAX_BYTES  (HEADER_MAX_BYTES),
    .LENGTH_MAX_DIGITS (LENGTH_MAX_DIGITS)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (s1_adv),
    .sample_bit_i    (s1_bit_q),
    .first_pixel_i   (s1_first_q),
    .header_word_i   (header_word_q),
    .header_length_i (header_length_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  assign res_o.valid     = out_valid_q;
  assign res_o.data_byte = out_q.data_byte;
  assign res_o.status    = out_q.status;
  assign res_o.last      = out_q.last;

`ifndef SYNTHESIS
  // Error results always close the stream and carry a zero byte.
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_DATA) |-> (out_q.last && out_q.data_byte == '0))
    else $error("error result without last or with non-zero data");

  // The pixel port only stalls while the input stage holds a pixel.
  a_stall_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (s1_valid_q && out_valid_q && !res_o.ready))
    else $error("pixel port stalled without a held pixel");

  // A stalled result is never overwritten by a parser step.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |-> !s1_adv)
    else $error("parser stepped while the output register was blocked");
`endif

endmodule

// ===== sim/lse_payload_checker.sv =====
`timescale 1ns / 100ps
// Checker for the LSB payload extractor: tracks the parser and compares every result item.
module lse_payload_checker #(
  parameter int unsigned HEADER_MAX_BYTES  = 8,
  parameter int unsigned LENGTH_MAX_DIGITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pix_valid_i,
  input  logic                           pix_ready_i,
  input  logic [lse_pkg::BYTE_W-1:0]     red_sample_i,
  input  logic                           first_pixel_i,
  input  logic                           res_valid_i,
  input  logic                           res_ready_i,
  input  logic [lse_pkg::BYTE_W-1:0]     data_byte_i,
  input  logic [lse_pkg::STATUS_W-1:0]   status_i,
  input  logic                           last_i,
  input  logic                           cfg_we_i,
  input  logic [lse_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lse_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    pending_o,
  output int unsigned                    fail_count_o
);
  import lse_pkg::*;

  localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
  localparam int unsigned       PRINT_LIMIT = 100;

  logic [HDR_WORD_W-1:0] hword_reg;
  logic [HDR_LEN_W-1:0]  hlen_reg;

  logic [BYTE_W-1:0]   gather;
  logic [BITPOS_W-1:0] bit_cnt;
  phase_e              phase;
  logic [POS_W-1:0]    byte_cnt;
  logic                hdr_match;
  logic [LEN_W-1:0]    length_acc;
  logic [LEN_W-1:0]    bytes_due;

  result_t     expected_q[$];
  int unsigned mismatches = 0;

  assign fail_count_o = mismatches;

  // Printing stops after a while so that a broken block cannot flood the log.
  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t: result mismatch, %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  function automatic void restart_parse();
    gather     = '0;
    bit_cnt    = '0;
    phase      = PH_HEADER;
    byte_cnt   = '0;
    hdr_match  = 1'b1;
    length_acc = '0;
    bytes_due  = '0;
  endfunction

  function automatic int unsigned active_header_len();
    if (hlen_reg == 0) return 1;
    if (hlen_reg > HEADER_MAX_BYTES) return HEADER_MAX_BYTES;
    return 32'(hlen_reg);
  endfunction

  // One pixel through the parser; returns 1 when the pixel produces a result item.
  function automatic bit parse_pixel(input logic lsb, input logic first, output result_t res);
    logic [BYTE_W-1:0]     byte_v;
    logic [HDR_WORD_W-1:0] shifted;
    logic [31:0]           acc;
    int unsigned           hlen;
    res.data_byte = '0;
    res.status    = ST_DATA;
    res.last      = 1'b0;
    if (first) restart_parse();
    if (phase == PH_DONE) return 1'b0;
    gather = {gather[BYTE_W-2:0], lsb};
    if (bit_cnt != 3'd7) begin
      bit_cnt = bit_cnt + 1'b1;
      return 1'b0;
    end
    byte_v  = gather;
    gather  = '0;
    bit_cnt = '0;

    if (phase == PH_HEADER) begin
      hlen = active_header_len();
      if (byte_cnt < hlen) begin
        shifted = hword_reg >> (8 * (hlen - 1 - byte_cnt));
        if (byte_v != shifted[BYTE_W-1:0]) hdr_match = 1'b0;
      end else begin
        hdr_match = 1'b0;
      end
      if (byte_cnt + 1 >= hlen) begin
        if (hdr_match) begin
          phase      = PH_LENGTH;
          byte_cnt   = '0;
          length_acc = '0;
          return 1'b0;
        end
        phase      = PH_DONE;
        res.status = ST_BAD_HEADER;
        res.last   = 1'b1;
        return 1'b1;
      end
      byte_cnt = byte_cnt + 1'b1;
      return 1'b0;
    end

    if (phase == PH_LENGTH) begin
      if (byte_v >= CHAR_ZERO && byte_v <= CHAR_NINE && byte_cnt < LENGTH_MAX_DIGITS) begin
        acc        = length_acc * 10 + (byte_v - CHAR_ZERO);
        length_acc = acc[LEN_W-1:0];
        byte_cnt   = byte_cnt + 1'b1;
        if (byte_cnt >= LENGTH_MAX_DIGITS) begin
          if (length_acc == 0) begin
            phase      = PH_DONE;
            res.status = ST_ZERO_LENGTH;
            res.last   = 1'b1;
            return 1'b1;
          end
          phase     = PH_PAYLOAD;
          bytes_due = length_acc;
        end
        return 1'b0;
      end
      if (length_acc == 0) begin
        phase      = PH_DONE;
        res.status = ST_ZERO_LENGTH;
        res.last   = 1'b1;
        return 1'b1;
      end
      // The byte that ends the digits is already the first payload byte.
      phase     = PH_PAYLOAD;
      bytes_due = length_acc;
    end

    if (bytes_due == 0) begin
      phase = PH_DONE;
      return 1'b0;
    end
    bytes_due     = bytes_due - 1'b1;
    res.data_byte = byte_v;
    res.last      = (bytes_due == 0);
    if (bytes_due == 0) phase = PH_DONE;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t want;
    result_t fresh;
    if (!rst_ni) begin
      hword_reg = '0;
      hlen_reg  = HDR_LEN_RESET;
      restart_parse();
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result item with nothing expected", data_byte_i, '0);
        end else begin
          want = expected_q.pop_front();
          if (data_byte_i !== want.data_byte) report_mismatch("data_byte", data_byte_i, want.data_byte);
          if (status_i !== want.status) begin
            report_mismatch("status", BYTE_W'(status_i), BYTE_W'(want.status));
          end
          if (last_i !== want.last) report_mismatch("last", BYTE_W'(last_i), BYTE_W'(want.last));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HEADER_WORD:   hword_reg = cfg_data_i;
          CFG_HEADER_LENGTH: hlen_reg  = cfg_data_i[HDR_LEN_W-1:0];
          default: ;
        endcase
      end
      if (pix_valid_i && pix_ready_i) begin
        if (parse_pixel(red_sample_i[0], first_pixel_i, fresh)) expected_q.push_back(fresh);
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench top of the LSB payload extractor: stimulus, back-pressure, watchdog and verdict.
module tb;
  import lse_pkg::*;

  localparam int unsigned HEADER_MAX_BYTES  = 8;
  localparam int unsigned LENGTH_MAX_DIGITS = 8;
  // Pixels to send over the whole run; the random part fills up to this count.
  localparam int unsigned TOTAL_PIXELS = 950;
  // Settling wait after draining, so that a pixel that causes no result can leave the block.
  localparam int unsigned SETTLE_CYCLES = 6;
  // Cycles with no item moving on either channel before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned WHOLE_IMAGE = 32'hFFFF_FFFF;
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lse_pixel_if  pix ();
  lse_result_if res ();

  int unsigned pending_results;
  int unsigned fail_count;
  int unsigned quiet_cycles = 0;

  // The stimulus keeps its own copy of the registers so that it can build matching headers.
  logic [HDR_WORD_W-1:0] hword_cfg;
  logic [HDR_LEN_W-1:0]  hlen_cfg;

  // Byte image of the next picture, sent eight pixels per byte, most significant bit first.
  logic [BYTE_W-1:0] image_q[$];
  int unsigned       burst_left;
  int unsigned       pixels_sent;

  lsb_stego_payload_extractor #(
    .HEADER_MAX_BYTES (HEADER_MAX_BYTES),
    .LENGTH_MAX_DIGITS(LENGTH_MAX_DIGITS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix),
    .res_o     (res),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  lse_payload_checker #(
    .HEADER_MAX_BYTES (HEADER_MAX_BYTES),
    .LENGTH_MAX_DIGITS(LENGTH_MAX_DIGITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_valid_i  (pix.valid),
    .pix_ready_i  (pix.ready),
    .red_sample_i (pix.red_sample),
    .first_pixel_i(pix.first_pixel),
    .res_valid_i  (res.valid),
    .res_ready_i  (res.ready),
    .data_byte_i  (res.data_byte),
    .status_i     (res.status),
    .last_i       (res.last),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending_results),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The result side stalls on a pattern of its own: it switches every so often between
  // always ready, a fair coin, mostly stalled and mostly ready.
  initial begin : result_backpressure
    int unsigned mode;
    res.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(16, 200)) begin
        @(posedge clk_i);
        case (mode)
          0:       res.ready <= 1'b1;
          1:       res.ready <= ($urandom_range(0, 1) == 0);
          2:       res.ready <= ($urandom_range(0, 3) == 0);
          default: res.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Watchdog: a run in which nothing moves for a long time has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (pix.valid && pix.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned header_len_now();
    if (hlen_cfg == 0) return 1;
    if (hlen_cfg > HEADER_MAX_BYTES) return HEADER_MAX_BYTES;
    return 32'(hlen_cfg);
  endfunction

  // Header byte i as the block expects it: the first byte sits in the top occupied byte.
  function automatic logic [BYTE_W-1:0] header_byte(input int unsigned i);
    logic [HDR_WORD_W-1:0] shifted;
    shifted = hword_cfg >> (8 * (header_len_now() - 1 - i));
    return shifted[BYTE_W-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] random_non_digit();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b >= CHAR_ZERO && b <= CHAR_NINE);
    return b;
  endfunction

  // Registers are only written while the block is idle. The length register gets random
  // upper data bits, which the block must ignore.
  task automatic set_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    if (idx == CFG_HEADER_WORD) hword_cfg = value;
    else hlen_cfg = value[HDR_LEN_W-1:0];
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_header_length(input int unsigned len);
    logic [CFG_DATA_W-1:0] value;
    value = {$urandom, $urandom};
    value[HDR_LEN_W-1:0] = HDR_LEN_W'(len);
    set_register(CFG_HEADER_LENGTH, value);
  endtask

  // Sends one pixel whose least significant bit is lsb; the other red bits are random.
  // The sender works in bursts: at the end of each one it may pause for a random gap.
  task automatic send_pixel(input logic lsb, input logic first);
    logic [BYTE_W-1:0] red;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        pix.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
    red    = BYTE_W'($urandom_range(0, 255));
    red[0] = lsb;
    pix.valid       <= 1'b1;
    pix.red_sample  <= red;
    pix.first_pixel <= first;
    do @(posedge clk_i); while (!pix.ready);
    pixels_sent++;
  endtask

  // Builds a picture: the header that matches the registers (one byte spoiled on request),
  // the length in the given number of decimal digits with leading zeros, the payload, and
  // some trailing bytes that the block must ignore.
  task automatic build_image(input int unsigned length_val, input int unsigned digits,
                             input bit spoil_header, input int unsigned tail);
    logic [BYTE_W-1:0] digit_q[$];
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] flip;
    int unsigned       eff;
    int unsigned       spoil_at;
    int unsigned       rest;
    int unsigned       payload_len;
    image_q.delete();
    eff      = header_len_now();
    spoil_at = $urandom_range(0, eff - 1);
    for (int unsigned i = 0; i < eff; i++) begin
      b = header_byte(i);
      if (spoil_header && i == spoil_at) begin
        flip = BYTE_W'($urandom_range(1, 255));
        b    = b ^ flip;
      end
      image_q.push_back(b);
    end
    rest = length_val;
    for (int unsigned i = 0; i < digits; i++) begin
      b = CHAR_ZERO + BYTE_W'(rest % 10);
      digit_q.push_front(b);
      rest = rest / 10;
    end
    foreach (digit_q[i]) image_q.push_back(digit_q[i]);
    // Below the digit limit the byte after the digits must be a non-digit, and it is
    // already payload. At the limit the next byte is payload whatever it holds, so a
    // digit there is tried now and then.
    payload_len = (length_val == 0) ? 1 : length_val;
    for (int unsigned p = 0; p < payload_len; p++) begin
      b = BYTE_W'($urandom_range(0, 255));
      if (p == 0 && digits < LENGTH_MAX_DIGITS) begin
        b = random_non_digit();
      end else if (p == 0 && length_val != 0 && $urandom_range(0, 1) == 0) begin
        b = CHAR_ZERO + BYTE_W'($urandom_range(0, 9));
      end
      image_q.push_back(b);
    end
    repeat (tail) image_q.push_back(BYTE_W'($urandom_range(0, 255)));
  endtask

  // Sends the built picture, cut short after pixel_limit pixels.
  task automatic send_image(input int unsigned pixel_limit);
    int unsigned n;
    n = 0;
    foreach (image_q[k]) begin
      for (int i = BYTE_W - 1; i >= 0; i--) begin
        if (n < pixel_limit) send_pixel(image_q[k][i], k == 0 && i == BYTE_W - 1);
        n++;
      end
    end
  endtask

  // Stops the sender and waits until every expected result item has come back, then lets
  // any pixel that causes no result leave the pipeline.
  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned length_val;
    int unsigned digits;
    int unsigned images;
    int unsigned hl;
    logic [HDR_WORD_W-1:0] hw;

    pix.valid       <= 1'b0;
    pix.red_sample  <= '0;
    pix.first_pixel <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_HEADER_WORD;
    cfg_data        <= '0;
    hword_cfg   = '0;
    hlen_cfg    = HDR_LEN_RESET;
    burst_left  = 0;
    pixels_sent = 0;
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers at their reset values: four zero header bytes, then a one-digit length.
    build_image(3, 1, 1'b0, 1);
    send_image(WHOLE_IMAGE);

    // A one-byte header of all ones; a length of one makes the first byte also the last.
    drain();
    set_header_length(1);
    set_register(CFG_HEADER_WORD, '1);
    build_image(1, 1, 1'b0, 0);
    send_image(WHOLE_IMAGE);
    // Eight digits with leading zeros: the next byte is payload even if it is a digit.
    build_image(2, LENGTH_MAX_DIGITS, 1'b0, 0);
    send_image(WHOLE_IMAGE);
    // Zero length after one digit, after eight zero digits and with no digit at all.
    build_image(0, 1, 1'b0, 1);
    send_image(WHOLE_IMAGE);
    build_image(0, LENGTH_MAX_DIGITS, 1'b0, 0);
    send_image(WHOLE_IMAGE);
    build_image(0, 0, 1'b0, 0);
    send_image(WHOLE_IMAGE);

    // The longest header: a spoiled byte is only reported once all eight have been read.
    drain();
    set_header_length(HEADER_MAX_BYTES);
    set_register(CFG_HEADER_WORD, {$urandom, $urandom});
    build_image(1, 1, 1'b1, 0);
    send_image(WHOLE_IMAGE);
    // A leading zero counts as an ordinary digit.
    build_image(2, 2, 1'b0, 0);
    send_image(WHOLE_IMAGE);

    // Out-of-range header lengths: zero acts as one, anything above eight as eight.
    drain();
    set_header_length(0);
    build_image(1, 1, 1'b0, 0);
    send_image(WHOLE_IMAGE);
    drain();
    set_header_length(15);
    build_image(1, 1, 1'b0, 0);
    send_image(WHOLE_IMAGE);
    drain();
    set_header_length(9);
    build_image(1, 1, 1'b1, 0);
    send_image(WHOLE_IMAGE);

    // A first pixel in the middle of a payload restarts the parse.
    drain();
    set_header_length(2);
    build_image(5, 1, 1'b0, 0);
    send_image(image_q.size() * BYTE_W / 2 + 3);
    build_image(2, 1, 1'b0, 0);
    send_image(WHOLE_IMAGE);

    // The header length is lowered to one after two header bytes: the third byte is
    // already past the new end and counts as a mismatch. The pixels after that error
    // are ignored until the next first pixel.
    drain();
    set_header_length(4);
    set_register(CFG_HEADER_WORD, {$urandom, $urandom});
    build_image(1, 1, 1'b0, 0);
    send_image(2 * BYTE_W);
    drain();
    set_header_length(1);
    repeat (3 * BYTE_W) send_pixel(1'($urandom_range(0, 1)), 1'b0);

    // Random part: mostly well-formed pictures with random content and settings, the rest
    // spoiled headers, zero lengths, pictures cut short and loose noise.
    images      = 0;
    while (pixels_sent < TOTAL_PIXELS) begin
      if (images % 4 == 0) begin
        drain();
        case ($urandom_range(0, 9))
          0:       hl = 0;
          1:       hl = $urandom_range(HEADER_MAX_BYTES + 1, 15);
          2:       hl = HEADER_MAX_BYTES;
          default: hl = $urandom_range(1, 4);
        endcase
        set_header_length(hl);
        case ($urandom_range(0, 3))
          0:       hw = '0;
          1:       hw = '1;
          default: hw = {$urandom, $urandom};
        endcase
        set_register(CFG_HEADER_WORD, hw);
      end
      images++;
      pick       = $urandom_range(0, 99);
      length_val = $urandom_range(1, 12);
      digits     = (length_val >= 10) ? 2 : 1;
      if ($urandom_range(0, 6) == 0) digits = LENGTH_MAX_DIGITS;
      else if ($urandom_range(0, 6) == 0) digits++;
      if (pick < 65) begin
        build_image(length_val, digits, 1'b0, $urandom_range(0, 1));
        send_image(WHOLE_IMAGE);
      end else if (pick < 75) begin
        build_image(length_val, digits, 1'b1, 0);
        send_image(WHOLE_IMAGE);
      end else if (pick < 82) begin
        digits = $urandom_range(0, 3);
        if (digits == 3) digits = LENGTH_MAX_DIGITS;
        build_image(0, digits, 1'b0, $urandom_range(0, 2));
        send_image(WHOLE_IMAGE);
      end else if (pick < 92) begin
        build_image(length_val, digits, 1'b0, 0);
        send_image($urandom_range(1, image_q.size() * BYTE_W - 1));
      end else begin
        repeat ($urandom_range(4, 40)) begin
          send_pixel(1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0);
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lse_pkg.sv
design/lse_if.sv
design/lse_parser.sv
design/lsb_stego_payload_extractor.sv
sim/lse_payload_checker.sv
sim/tb.sv
